[design/plst_pkg.sv]
package plst_pkg;

    // command codes carried by a request transaction
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_FIND   = 2'd3
    } plst_cmd_t;

    // status codes carried by a response transaction
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } plst_status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } plst_state_t;

    // per-cycle control broadcast to every cell of the row
    typedef struct packed {
        logic shift_in;
        logic shift_out;
        logic seek_index;
        logic seek_value;
    } plst_ctrl_t;

    // cells between two registers of the search carry
    localparam int SCAN_HOP = 8;

endpackage

[design/plst_if.sv]
interface plst_in_if import plst_pkg::*; ();
    logic              valid;
    logic              ready;
    plst_cmd_t         command;
    logic signed [7:0] position;
    logic        [7:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface plst_out_if import plst_pkg::*; ();
    logic         valid;
    logic         ready;
    logic [7:0]   read_value;
    logic [4:0]   found_position;
    logic         found;
    logic [5:0]   entry_count;
    plst_status_t status;

    modport source (output valid, read_value, found_position, found, entry_count, status,
                    input ready);
    modport sink   (input valid, read_value, found_position, found, entry_count, status,
                    output ready);
endinterface

[design/plst_cell.sv]
module plst_cell import plst_pkg::*; #(
    parameter int ELEMENT_BITS = 8,
    parameter int IDX_W        = 5,
    parameter int CNT_W        = 6
) (
    input  logic                    clk,
    input  plst_ctrl_t              ctrl,
    input  logic [IDX_W-1:0]        cell_index,
    input  logic [IDX_W-1:0]        target,
    input  logic [CNT_W-1:0]        count,
    input  logic [ELEMENT_BITS-1:0] key,
    input  logic [ELEMENT_BITS-1:0] left_data,
    input  logic [ELEMENT_BITS-1:0] right_data,
    output logic [ELEMENT_BITS-1:0] data,
    input  logic                    hit_in,
    input  logic [ELEMENT_BITS-1:0] data_in,
    input  logic [IDX_W-1:0]        pos_in,
    output logic                    hit_out,
    output logic [ELEMENT_BITS-1:0] data_out,
    output logic [IDX_W-1:0]        pos_out
);

    logic [ELEMENT_BITS-1:0] data_reg;
    logic [ELEMENT_BITS-1:0] data_next;
    logic                    active;
    logic                    take;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_in)
        begin
            if (cell_index > target)
                data_next = left_data;
            else if (cell_index == target)
                data_next = key;
        end
        else if (ctrl.shift_out)
        begin
            if (cell_index >= target)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data   = data_reg;
    assign active = CNT_W'(cell_index) < count;

    // first qualifying cell along the row claims the carry
    assign take = !hit_in && active &&
                  ((ctrl.seek_index && (cell_index == target)) ||
                   (ctrl.seek_value && (data_reg == key)));

    assign hit_out  = hit_in | take;
    assign data_out = take ? data_reg : data_in;
    assign pos_out  = take ? cell_index : pos_in;

endmodule

[design/positional_list_store_unit.sv]
// channel    | role   | payload
// -----------+--------+----------------------------------------------------------
// request    | sink   | command, position (signed), value
// response   | source | read_value, found_position, found, entry_count, status
//
// insert and remove: the request is latched, then the whole cell row shifts once;
// the result is written with that shift, held until the output register is free
// read and find: the request is latched, then the search carry crosses the row,
// registered after every eight cells, and the result is written when the carry
// has left the last cell and the output register is free
// one request in flight; the next is taken the cycle after its result is written
// reset clears the count and the control; cell contents are left as they are
// a stalled response holds in the output register; a new request is still taken
// and its result waits until that register drains
module positional_list_store_unit import plst_pkg::*; #(
    parameter int CAPACITY     = 32,
    parameter int ELEMENT_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    plst_in_if.sink     request,
    plst_out_if.source  response
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NG    = (CAPACITY + SCAN_HOP - 1) / SCAN_HOP;
    localparam int HOP_W = (NG > 1) ? $clog2(NG) : 1;
    localparam int CW    = (CNT_W > 7) ? CNT_W : 7;

    // control state
    plst_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [HOP_W-1:0]   hop_reg, hop_next;
    logic               resp_valid_reg;

    // latched request
    plst_cmd_t               cmd_op_reg;
    logic signed [7:0]       pos_op_reg;
    logic [ELEMENT_BITS-1:0] key_op_reg;

    // response payload
    logic [7:0]         resp_read_reg;
    logic [4:0]         resp_fpos_reg;
    logic               resp_found_reg;
    logic [5:0]         resp_count_reg;
    plst_status_t       resp_status_reg;

    logic                      accept;
    logic                      fire;
    logic                      is_update;
    logic                      scan_last;
    logic                      out_free;
    logic                      full;
    logic                      empty;
    logic [ELEMENT_BITS+7:0]   value_ext;
    logic [CW-1:0]             pos_mag, hi_lim, clamp_w;
    logic [IDX_W-1:0]          target;
    plst_ctrl_t                ctrl;
    plst_status_t              status_next;

    // row of cells and its search carry
    logic [ELEMENT_BITS-1:0] cell_data [CAPACITY];
    logic                    ci_hit    [CAPACITY];
    logic [ELEMENT_BITS-1:0] ci_data   [CAPACITY];
    logic [IDX_W-1:0]        ci_pos    [CAPACITY];
    logic                    co_hit    [CAPACITY];
    logic [ELEMENT_BITS-1:0] co_data   [CAPACITY];
    logic [IDX_W-1:0]        co_pos    [CAPACITY];

    logic                    fin_hit;
    logic [ELEMENT_BITS+7:0] rd_ext;
    logic [IDX_W+4:0]        fpos_ext;
    logic [CNT_W+5:0]        cnt_ext;

    assign value_ext = {{ELEMENT_BITS{1'b0}}, request.value};
    assign full      = count_reg == CNT_W'(CAPACITY);
    assign empty     = count_reg == '0;
    assign accept    = request.valid && request.ready;

    // clamp: negative goes to the front, past the limit goes to the limit
    // (count for insert, last element for remove and read)
    assign pos_mag = CW'(pos_op_reg[6:0]);
    assign hi_lim  = (cmd_op_reg == CMD_INSERT) ? CW'(count_reg) : CW'(count_reg) - CW'(1);
    assign clamp_w = pos_op_reg[7] ? '0 : ((pos_mag > hi_lim) ? hi_lim : pos_mag);
    assign target  = clamp_w[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            hop_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            hop_reg   <= hop_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        hop_next        = hop_reg;
        request.ready   = 1'b0;
        fire            = 1'b0;
        is_update       = (cmd_op_reg == CMD_INSERT) || (cmd_op_reg == CMD_REMOVE);
        scan_last       = hop_reg == HOP_W'(NG - 1);
        out_free        = !resp_valid_reg || response.ready;
        ctrl.shift_in   = 1'b0;
        ctrl.shift_out  = 1'b0;
        ctrl.seek_index = cmd_op_reg == CMD_READ;
        ctrl.seek_value = cmd_op_reg == CMD_FIND;
        status_next     = ST_OK;

        case (cmd_op_reg)
            CMD_INSERT: if (full)  status_next = ST_FULL;
            CMD_REMOVE: if (empty) status_next = ST_EMPTY;
            default:    status_next = ST_OK;
        endcase

        case (state_reg)
            S_IDLE:
            begin
                request.ready = 1'b1;
                if (request.valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!is_update && !scan_last)
                    hop_next = hop_reg + HOP_W'(1);
                else if (out_free)
                begin
                    fire       = 1'b1;
                    hop_next   = '0;
                    state_next = S_IDLE;
                    if ((cmd_op_reg == CMD_INSERT) && !full)
                    begin
                        ctrl.shift_in = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                    if ((cmd_op_reg == CMD_REMOVE) && !empty)
                    begin
                        ctrl.shift_out = 1'b1;
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_op_reg <= request.command;
            pos_op_reg <= request.position;
            key_op_reg <= value_ext[ELEMENT_BITS-1:0];
        end
    end

    // the row: shifts on insert and remove, search carry ripples through it
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign ci_hit[g]  = 1'b0;
            assign ci_data[g] = '0;
            assign ci_pos[g]  = '0;
        end
        else if ((g % SCAN_HOP) == 0)
        begin : g_hop
            logic                    hit_reg;
            logic [ELEMENT_BITS-1:0] data_reg;
            logic [IDX_W-1:0]        pos_reg;

            always_ff @(posedge clk)
            begin
                hit_reg  <= co_hit[g-1];
                data_reg <= co_data[g-1];
                pos_reg  <= co_pos[g-1];
            end

            assign ci_hit[g]  = hit_reg;
            assign ci_data[g] = data_reg;
            assign ci_pos[g]  = pos_reg;
        end
        else
        begin : g_link
            assign ci_hit[g]  = co_hit[g-1];
            assign ci_data[g] = co_data[g-1];
            assign ci_pos[g]  = co_pos[g-1];
        end

        plst_cell #(
            .ELEMENT_BITS (ELEMENT_BITS),
            .IDX_W        (IDX_W),
            .CNT_W        (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .cell_index (IDX_W'(g)),
            .target     (target),
            .count      (count_reg),
            .key        (key_op_reg),
            .left_data  ((g == 0) ? cell_data[g] : cell_data[(g == 0) ? 0 : g - 1]),
            .right_data ((g == CAPACITY - 1) ? cell_data[g]
                                             : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
            .data       (cell_data[g]),
            .hit_in     (ci_hit[g]),
            .data_in    (ci_data[g]),
            .pos_in     (ci_pos[g]),
            .hit_out    (co_hit[g]),
            .data_out   (co_data[g]),
            .pos_out    (co_pos[g])
        );
    end

    assign fin_hit  = co_hit[CAPACITY-1];
    assign rd_ext   = {8'b0, co_data[CAPACITY-1]};
    assign fpos_ext = {5'b0, co_pos[CAPACITY-1]};
    assign cnt_ext  = {6'b0, count_next};

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            resp_valid_reg <= 1'b0;
        else if (fire)
            resp_valid_reg <= 1'b1;
        else if (response.ready)
            resp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            resp_read_reg   <= ((cmd_op_reg == CMD_READ) && fin_hit) ? rd_ext[7:0] : 8'd0;
            resp_fpos_reg   <= ((cmd_op_reg == CMD_FIND) && fin_hit) ? fpos_ext[4:0] : 5'd0;
            resp_found_reg  <= (cmd_op_reg == CMD_FIND) && fin_hit;
            resp_count_reg  <= cnt_ext[5:0];
            resp_status_reg <= status_next;
        end
    end

    assign response.valid          = resp_valid_reg;
    assign response.read_value     = resp_read_reg;
    assign response.found_position = resp_fpos_reg;
    assign response.found          = resp_found_reg;
    assign response.entry_count    = resp_count_reg;
    assign response.status         = resp_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted transaction not under execution");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(count_reg))
        else $error("count moved without a finished transaction");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid_reg && (resp_status_reg == ST_FULL)) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("full status reported while list not full");

    a_update_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_update) |-> (hop_reg == '0))
        else $error("insert or remove finished with a search in progress");
`endif

endmodule

[sim/plst_list_checker.sv]
`timescale 1ns / 100ps

// watches both channels, keeps its own copy of the list and checks every response
module plst_list_checker import plst_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  logic clk,
    input  logic rst_n,
    plst_in_if   request,
    plst_out_if  response,
    output int   mismatches,
    output int   outstanding
);

    typedef struct {
        logic [7:0]   read_value;
        logic [4:0]   found_position;
        logic         found;
        logic [5:0]   entry_count;
        plst_status_t status;
    } list_result_t;

    logic [7:0]   stored_elements[$];
    list_result_t pending_results[$];

    // clamp a signed position into 0..top
    function automatic int clamp_position(logic signed [7:0] pos, int top);
        int p;
        p = int'(pos);
        if (p < 0)
            p = 0;
        else if (p > top)
            p = top;
        return p;
    endfunction

    // applies one command to the stored list and returns the response it should give
    function automatic list_result_t apply_command(plst_cmd_t cmd, logic signed [7:0] pos,
                                                   logic [7:0] val);
        list_result_t r;
        int           count;
        int           p;
        r.read_value     = '0;
        r.found_position = '0;
        r.found          = 1'b0;
        r.status         = ST_OK;
        count            = stored_elements.size();
        case (cmd)
            CMD_INSERT:
                if (count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    p = clamp_position(pos, count);
                    stored_elements.insert(p, val);
                end
            CMD_REMOVE:
                if (count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    p = clamp_position(pos, count - 1);
                    stored_elements.delete(p);
                end
            CMD_READ:
                if (count != 0)
                    r.read_value = stored_elements[clamp_position(pos, count - 1)];
            default:
                for (int i = 0; i < count; i++)
                begin
                    if (stored_elements[i] == val)
                    begin
                        r.found          = 1'b1;
                        r.found_position = 5'(i);
                        break;
                    end
                end
        endcase
        r.entry_count = 6'(stored_elements.size());
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t ns: response %s is %0d, %0d expected", $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n)
        begin
            if (request.valid && request.ready)
                pending_results.push_back(apply_command(request.command, request.position,
                                                        request.value));
            if (response.valid && response.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("transaction with none outstanding, count",
                                    int'(response.entry_count), -1);
                else
                begin
                    want = pending_results.pop_front();
                    if (response.read_value !== want.read_value)
                        report_mismatch("read_value", int'(response.read_value),
                                        int'(want.read_value));
                    if (response.found_position !== want.found_position)
                        report_mismatch("found_position", int'(response.found_position),
                                        int'(want.found_position));
                    if (response.found !== want.found)
                        report_mismatch("found", int'(response.found), int'(want.found));
                    if (response.entry_count !== want.entry_count)
                        report_mismatch("entry_count", int'(response.entry_count),
                                        int'(want.entry_count));
                    if (response.status !== want.status)
                        report_mismatch("status", int'(response.status), int'(want.status));
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb import plst_pkg::*; ();

    // how the random commands lean: grow the list, shrink it, or stir it
    typedef enum int {
        LEAN_FILL,
        LEAN_DRAIN,
        LEAN_CHURN
    } list_lean_t;

    localparam int RANDOM_ITEMS  = 1830;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n;

    plst_in_if  request_ch();
    plst_out_if response_ch();

    int mismatches;
    int outstanding;

    // no idling on either side while this is set
    bit calm;
    // asks the response side for one long hold-off
    bit hold_armed;

    positional_list_store_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    plst_list_checker #(.CAPACITY(32)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request_ch),
        .response    (response_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial
    begin
        #1_600_000;
        $display("tb NOT OK");
        $finish;
    end

    // response side: random back-pressure plus one long hold-off counted here
    initial
    begin
        int hold_left;
        hold_left         = 0;
        response_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                response_ch.ready <= 1'b0;
            end
            else
                response_ch.ready <= calm || ($urandom_range(99) >= 27);
        end
    end

    // one request transaction; entered and left at a falling edge, valid left high
    // so that a following call raises nothing twice in the same step
    task automatic send_request(plst_cmd_t cmd, logic signed [7:0] pos, logic [7:0] val);
        if (!calm && $urandom_range(99) < 27)
        begin
            request_ch.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < 27);
        end
        request_ch.valid    <= 1'b1;
        request_ch.command  <= cmd;
        request_ch.position <= pos;
        request_ch.value    <= val;
        do
            @(posedge clk);
        while (!request_ch.ready);
        @(negedge clk);
    endtask

    // stop offering and wait until every response has come back
    task automatic drain_responses();
        request_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    // small values half the time so that finds hit and duplicates appear
    function automatic logic [7:0] pick_value();
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(7));
        return 8'($urandom_range(255));
    endfunction

    // mostly positions inside the list, plus negatives, anything, and the edges
    function automatic logic signed [7:0] pick_position();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 8'($urandom_range(33));
        if (r < 60)
            return 8'(-int'($urandom_range(128, 1)));
        if (r < 80)
            return 8'($urandom_range(255));
        case ($urandom_range(5))
            0:       return -8'sd128;
            1:       return -8'sd1;
            2:       return 8'sd0;
            3:       return 8'sd31;
            4:       return 8'sd32;
            default: return 8'sd127;
        endcase
    endfunction

    function automatic plst_cmd_t pick_command(list_lean_t lean);
        int w;
        int ins_lim;
        int rem_lim;
        w = $urandom_range(99);
        case (lean)
            LEAN_FILL:
            begin
                ins_lim = 55;
                rem_lim = 70;
            end
            LEAN_DRAIN:
            begin
                ins_lim = 15;
                rem_lim = 70;
            end
            default:
            begin
                ins_lim = 30;
                rem_lim = 55;
            end
        endcase
        if (w < ins_lim)
            return CMD_INSERT;
        if (w < rem_lim)
            return CMD_REMOVE;
        if (w < rem_lim + (100 - rem_lim) / 2)
            return CMD_READ;
        return CMD_FIND;
    endfunction

    initial
    begin
        list_lean_t lean;
        int         lean_left;
        int         hold_at;
        int         drain_at;
        int         calm_from;

        // everything known from time zero
        rst_n               = 1'b0;
        calm                = 1'b0;
        hold_armed          = 1'b0;
        request_ch.valid    = 1'b0;
        request_ch.command  = CMD_INSERT;
        request_ch.position = '0;
        request_ch.value    = '0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty list first
        send_request(CMD_READ,   8'sd0,    8'h00);
        send_request(CMD_FIND,   8'sd0,    8'h00);
        send_request(CMD_REMOVE, 8'sd0,    8'h00);   // refused, list empty
        // inserts at the clamped front, end, front and middle
        send_request(CMD_INSERT, -8'sd128, 8'h00);
        send_request(CMD_INSERT, 8'sd127,  8'hff);
        send_request(CMD_INSERT, 8'sd0,    8'haa);
        send_request(CMD_INSERT, 8'sd1,    8'h55);
        send_request(CMD_INSERT, 8'sd100,  8'h55);   // duplicate at the end
        // find takes the first of two matches, misses an absent element, hits a single one
        send_request(CMD_FIND,   8'sd0,    8'h55);
        send_request(CMD_FIND,   8'sd0,    8'h12);
        send_request(CMD_FIND,   -8'sd5,   8'h00);
        // reads at the clamped front, clamped end and inside
        send_request(CMD_READ,   -8'sd1,   8'h00);
        send_request(CMD_READ,   8'sd127,  8'h00);
        send_request(CMD_READ,   8'sd2,    8'h00);
        // removes at the end, the front, the middle, down to a single entry and past it
        send_request(CMD_REMOVE, 8'sd127,  8'h00);
        send_request(CMD_REMOVE, -8'sd128, 8'h00);
        send_request(CMD_REMOVE, 8'sd1,    8'h00);
        send_request(CMD_REMOVE, 8'sd0,    8'h00);
        send_request(CMD_REMOVE, 8'sd5,    8'h00);
        send_request(CMD_REMOVE, 8'sd0,    8'h00);
        send_request(CMD_READ,   8'sd3,    8'h00);
        send_request(CMD_INSERT, 8'sd32,   8'h80);

        // random: the lean switches now and then so the list runs full and empty
        hold_at   = $urandom_range(500, 300);
        drain_at  = $urandom_range(1100, 900);
        calm_from = $urandom_range(1400, 1200);
        lean      = LEAN_FILL;
        lean_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (lean_left == 0)
            begin
                case ($urandom_range(2))
                    0:       lean = LEAN_FILL;
                    1:       lean = LEAN_DRAIN;
                    default: lean = LEAN_CHURN;
                endcase
                lean_left = $urandom_range(150, 60);
            end
            lean_left--;

            // long receiver hold-off while requests keep coming
            if (n == hold_at)
                hold_armed = 1'b1;
            // sender pause until the block has answered everything
            if (n == drain_at)
                drain_responses();
            calm = (n >= calm_from) && (n < calm_from + 250);

            send_request(pick_command(lean), pick_position(), pick_value());
        end
        calm = 1'b0;
        request_ch.valid <= 1'b0;

        // wait for the last responses, then let any stray responses show up
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
